// ===== sv/blfp_pkg.sv =====
// Shared types, constants and register indexes of the battery level filter.
package blfp_pkg;

    // Field widths.
    localparam int MV_W   = 16;
    localparam int PCT_W  = 7;
    localparam int FV_W   = 32;
    localparam int IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_FULL  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_EMPTY = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ALPHA = 2'd2;

    // Configuration reset values.
    localparam logic [MV_W-1:0] FULL_RST  = 16'd4200;
    localparam logic [MV_W-1:0] EMPTY_RST = 16'd3300;
    localparam logic [MV_W-1:0] ALPHA_RST = 16'd6554;

    // Percent scale and the quotient divider length (quotient stays below 128).
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam int               DIV_STEPS = PCT_W;
    localparam int               STEP_W    = $clog2(DIV_STEPS);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // take the input request
        logic mul;       // form both filter products
        logic acc;       // add products into the filter state
        logic scale;     // scale filtered voltage, set clamp flags
        logic div_step;  // one restoring division step
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic started;   // filter holds a value
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

// ===== sv/blfp_ctrl.sv =====
// Controller state machine of the battery level filter.
module blfp_ctrl
    import blfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_last;

    assign w_last = (r_step == STEP_W'(DIV_STEPS - 1));

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state logic.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.started ? ST_MUL : ST_SCALE;
                end
            end
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = ST_SCALE;
            ST_SCALE: begin
                n_state = ST_DIV;
                n_step  = '0;
            end
            ST_DIV: begin
                n_step = r_step + 1'b1;
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_MUL:   o_cmd.mul      = 1'b1;
            ST_ACC:   o_cmd.acc      = 1'b1;
            ST_SCALE: o_cmd.scale    = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_DONE:  o_cmd.out_load = i_status.out_free;
            default:  o_cmd          = '0;
        endcase
    end

endmodule

// ===== sv/blfp_dpath.sv =====
// Datapath of the battery level filter: config, filter state, scaling and divider.
module blfp_dpath
    import blfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [MV_W-1:0]  i_cfg_data,
    input  logic [MV_W-1:0]  i_sample_mv,
    input  logic             i_out_stall,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_valid,
    output logic [PCT_W-1:0] o_percent,
    output logic [MV_W-1:0]  o_filtered_mv
);

    // Configuration registers.
    logic [MV_W-1:0] r_full, r_empty, r_alpha;

    // Filter state and working registers.
    logic [FV_W-1:0]      r_fv;
    logic                 r_started;
    logic [MV_W-1:0]      r_sample;
    logic [FV_W+16:0]     r_prod_a;
    logic [FV_W-1:0]      r_prod_b;
    logic [22:0]          r_rem;
    logic [21:0]          r_div;
    logic [PCT_W-1:0]     r_quo;
    logic                 r_hi, r_lo;
    logic                 r_out_valid;
    logic [PCT_W-1:0]     r_out_pct;
    logic [MV_W-1:0]      r_out_mv;

    logic [16:0]          w_keep;
    logic [FV_W:0]        w_sum;
    logic [FV_W-1:0]      w_top, w_bottom, w_diff;
    logic [38:0]          w_scaled;
    logic [MV_W-1:0]      w_span;
    logic [22:0]          w_trial;
    logic                 w_fit;
    logic [PCT_W-1:0]     w_pct;

    assign w_keep   = 17'h10000 - {1'b0, r_alpha};
    assign w_sum    = r_prod_a[FV_W+16:16] + {1'b0, r_prod_b};
    assign w_top    = {r_full, 16'h0000};
    assign w_bottom = {r_empty, 16'h0000};
    assign w_diff   = r_fv - w_bottom;
    assign w_scaled = 39'(w_diff) * 39'(PCT_FULL);
    assign w_span   = r_full - r_empty;
    assign w_fit    = (r_rem >= {1'b0, r_div});
    assign w_trial  = r_rem - {1'b0, r_div};
    assign w_pct    = r_hi ? PCT_FULL : (r_lo ? '0 : r_quo);

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= FULL_RST;
            r_empty <= EMPTY_RST;
            r_alpha <= ALPHA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FULL:  r_full  <= i_cfg_data;
                CFG_EMPTY: r_empty <= i_cfg_data;
                CFG_ALPHA: r_alpha <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Filter state: the first sample loads it, later ones blend in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv      <= '0;
            r_started <= 1'b0;
        end else if (i_cmd.load && !r_started) begin
            r_fv      <= {i_sample_mv, 16'h0000};
            r_started <= 1'b1;
        end else if (i_cmd.acc) begin
            r_fv <= w_sum[FV_W-1:0];
        end
    end

    // Products: old state times keep weight, new sample times alpha.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample_mv;
        end
        if (i_cmd.mul) begin
            r_prod_a <= (FV_W+17)'(r_fv) * (FV_W+17)'(w_keep);
            r_prod_b <= FV_W'(r_sample) * FV_W'(r_alpha);
        end
    end

    // Scaling, clamp flags and the restoring divider, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_rem <= w_scaled[38:16];
            r_div <= {w_span, 6'b000000};
            r_quo <= '0;
            r_hi  <= (r_fv >= w_top);
            r_lo  <= (r_fv <= w_bottom);
        end else if (i_cmd.div_step) begin
            if (w_fit) begin
                r_rem <= w_trial;
            end
            r_quo <= {r_quo[PCT_W-2:0], w_fit};
            r_div <= {1'b0, r_div[21:1]};
        end
    end

    // Output register holds the result until the request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pct <= w_pct;
            r_out_mv  <= r_fv[FV_W-1:16];
        end
    end

    assign o_status.started  = r_started;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_valid           = r_out_valid;
    assign o_percent         = r_out_pct;
    assign o_filtered_mv     = r_out_mv;

endmodule

// ===== sv/battery_level_filter_percent_core.sv =====
// Output valid rises after the result load; the first sample skips the filter multiply and accumulate states.
// One request at a time: a new request is taken only after load, filter, scale, 7 divider steps and
// the result load, and any stall on the output side holds it longer.
// Reset is synchronous, active low: filter unstarted, state zero, config to defaults.
// The first sample after reset loads the filter directly.
// Top level of the battery level filter with percent output.
module battery_level_filter_percent_core
    import blfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [MV_W-1:0]  i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [MV_W-1:0]  i_sample_mv,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PCT_W-1:0] o_percent,
    output logic [MV_W-1:0]  o_filtered_mv
);

    t_cmd    w_cmd;
    t_status w_status;

    blfp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_busy   (o_stall),
        .o_cmd    (w_cmd)
    );

    blfp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_sample_mv   (i_sample_mv),
        .i_out_stall   (i_stall),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_percent     (o_percent),
        .o_filtered_mv (o_filtered_mv)
    );

    // One request in flight: after an accept the input side stalls.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while a request is in flight");

    // A shown result is always a clamped percentage.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_percent <= PCT_FULL))
        else $error("percent above full scale");

    // Output valid rises only after the controller loaded a result.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load))
        else $error("output valid without a result load");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the battery level filter core with percent output.
module tb
    import blfp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it; writes to it are dropped.
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int RAND_PHASES = 10;
    localparam int PHASE_LEN   = 123;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYC    = 300;
    localparam int TAIL_CYC    = 30;
    localparam int CYCLE_LIMIT = 500000;

    // One battery level result: percent and integer filtered millivolts.
    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [MV_W-1:0]  fmv;
    } t_level;

    // One row of the directed table: a register write or a sample request.
    typedef struct packed {
        bit               is_cfg;
        logic [IDX_W-1:0] idx;
        logic [MV_W-1:0]  val;
        bit               typed;
        t_level           lvl;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [MV_W-1:0]  i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    logic [MV_W-1:0]  i_sample_mv;
    logic             o_valid;
    logic             i_stall;
    logic [PCT_W-1:0] o_percent;
    logic [MV_W-1:0]  o_filtered_mv;

    // Local copy of the filter state and the register settings.
    logic [FV_W-1:0] flt_v;
    bit              flt_started;
    logic [MV_W-1:0] cfg_full;
    logic [MV_W-1:0] cfg_empty;
    logic [MV_W-1:0] cfg_alpha;

    t_level   pending_levels[$];
    t_dir_row dir_tab[$];
    int       levels_seen = 0;
    int       mismatches  = 0;
    int       cycles      = 0;
    bit       idle_en     = 1'b1;
    bit       held        = 1'b0;

    battery_level_filter_percent_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_mv   (i_sample_mv),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_percent     (o_percent),
        .o_filtered_mv (o_filtered_mv)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advance the filter by one sample and work out the level it reports.
    function automatic t_level next_level(input logic [MV_W-1:0] s);
        logic [63:0]     acc;
        logic [FV_W-1:0] top;
        logic [FV_W-1:0] bottom;
        t_level          r;
        if (!flt_started) begin
            flt_v       = {s, 16'h0000};
            flt_started = 1'b1;
        end else begin
            acc   = 64'(flt_v) * (64'd65536 - 64'(cfg_alpha))
                  + 64'({s, 16'h0000}) * 64'(cfg_alpha);
            flt_v = acc[47:16];
        end
        top    = {cfg_full, 16'h0000};
        bottom = {cfg_empty, 16'h0000};
        // The full clamp wins when the thresholds cross.
        if (flt_v >= top) begin
            r.pct = PCT_FULL;
        end else if (flt_v <= bottom) begin
            r.pct = '0;
        end else begin
            acc   = (64'(flt_v - bottom) * 64'd100) / 64'(top - bottom);
            r.pct = acc[PCT_W-1:0];
        end
        r.fmv = flt_v[FV_W-1:16];
        return r;
    endfunction

    function automatic t_dir_row reg_row(input logic [IDX_W-1:0] idx,
                                         input logic [MV_W-1:0] val);
        t_dir_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic t_dir_row smp_row(input logic [MV_W-1:0] val);
        t_dir_row r;
        r     = '0;
        r.val = val;
        return r;
    endfunction

    function automatic t_dir_row known_row(input logic [MV_W-1:0] val,
                                           input logic [PCT_W-1:0] pct,
                                           input logic [MV_W-1:0] fmv);
        t_dir_row r;
        r         = '0;
        r.val     = val;
        r.typed   = 1'b1;
        r.lvl.pct = pct;
        r.lvl.fmv = fmv;
        return r;
    endfunction

    // Random sample, mostly near the band between the two thresholds.
    function automatic logic [MV_W-1:0] pick_sample();
        int lo;
        int hi;
        lo = ((cfg_full < cfg_empty) ? int'(cfg_full) : int'(cfg_empty)) - 300;
        hi = ((cfg_full > cfg_empty) ? int'(cfg_full) : int'(cfg_empty)) + 300;
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        if ($urandom_range(3) == 0) return MV_W'($urandom_range(65535, 0));
        return MV_W'($urandom_range(hi, lo));
    endfunction

    function automatic void flag_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        if (mismatches < 10)
            $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
        mismatches++;
    endfunction

    // Register write; enable stays high until the next request lowers it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MV_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_FULL:  cfg_full = val;
            CFG_EMPTY: cfg_empty = val;
            CFG_ALPHA: cfg_alpha = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Offer one sample request and record its level once it is taken.
    task automatic send_request(input logic [MV_W-1:0] s, input bit typed,
                                input t_level known);
        t_level lvl;
        i_cfg_we <= 1'b0;
        while (idle_en && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_mv <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        lvl = next_level(s);
        pending_levels.push_back(typed ? known : lvl);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every pending level has come back.
    task automatic drain();
        i_valid  <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver side: random stalls, one long hold-off to back the block up.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && levels_seen >= HOLD_AT) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYC) @(negedge i_clk);
            end
            i_stall <= idle_en && ($urandom_range(99) < 30);
        end
    end

    // Compare each result taken from the block with the oldest pending level.
    always @(posedge i_clk) begin : result_check
        t_level want;
        if (i_rst_n && o_valid && !i_stall) begin
            levels_seen++;
            if (pending_levels.size() == 0) begin
                flag_mismatch("result with nothing pending, filtered_mv", 0, o_filtered_mv);
            end else begin
                want = pending_levels.pop_front();
                if (o_percent !== want.pct) flag_mismatch("percent", want.pct, o_percent);
                if (o_filtered_mv !== want.fmv)
                    flag_mismatch("filtered_mv", want.fmv, o_filtered_mv);
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int               mode;
        int               full_v;
        int               empty_v;
        logic [MV_W-1:0]  alpha_v;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample_mv = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        flt_v       = '0;
        flt_started = 1'b0;
        cfg_full    = FULL_RST;
        cfg_empty   = EMPTY_RST;
        cfg_alpha   = ALPHA_RST;

        // Directed part: first sample loads the filter, zero alpha holds it so the
        // clamps, boundaries and truncation can be read off directly.
        dir_tab = '{
            known_row(16'd4200, 7'd100, 16'd4200),
            reg_row(CFG_ALPHA, 16'd0),
            known_row(16'd0, 7'd100, 16'd4200),
            known_row(16'd65535, 7'd100, 16'd4200),
            reg_row(CFG_FULL, 16'd0),
            reg_row(CFG_EMPTY, 16'd65535),
            known_row(16'd123, 7'd100, 16'd4200),
            reg_row(CFG_FULL, 16'd5000),
            reg_row(CFG_EMPTY, 16'd4200),
            known_row(16'd0, 7'd0, 16'd4200),
            reg_row(CFG_FULL, 16'd5200),
            reg_row(CFG_EMPTY, 16'd3200),
            known_row(16'd9999, 7'd50, 16'd4200),
            reg_row(CFG_FULL, 16'd4300),
            reg_row(CFG_EMPTY, 16'd4199),
            known_row(16'd1, 7'd0, 16'd4200),
            reg_row(CFG_FULL, 16'd4201),
            reg_row(CFG_EMPTY, 16'd4100),
            known_row(16'd7, 7'd99, 16'd4200),
            reg_row(CFG_FULL, 16'd4200),
            reg_row(CFG_EMPTY, 16'd4200),
            known_row(16'd4200, 7'd100, 16'd4200),
            reg_row(CFG_FULL, 16'd4199),
            reg_row(CFG_EMPTY, 16'd4201),
            known_row(16'd4200, 7'd100, 16'd4200),
            reg_row(CFG_ALPHA, 16'd65535),
            reg_row(CFG_FULL, 16'd65535),
            reg_row(CFG_EMPTY, 16'd0),
            smp_row(16'd0),
            smp_row(16'd65535),
            smp_row(16'd65535),
            smp_row(16'd32768),
            reg_row(CFG_ALPHA, 16'd1),
            smp_row(16'd0),
            smp_row(16'd65535),
            reg_row(CFG_SPARE, 16'd65535),
            smp_row(16'd21845),
            smp_row(16'd43690),
            reg_row(CFG_FULL, FULL_RST),
            reg_row(CFG_EMPTY, EMPTY_RST),
            reg_row(CFG_ALPHA, ALPHA_RST),
            smp_row(16'd3300),
            smp_row(16'd3750),
            smp_row(16'd4200),
            smp_row(16'd65535),
            smp_row(16'd0)
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[n]) begin
            if (dir_tab[n].is_cfg) begin
                if (n == 0 || !dir_tab[n-1].is_cfg) drain();
                write_reg(dir_tab[n].idx, dir_tab[n].val);
            end else begin
                send_request(dir_tab[n].val, dir_tab[n].typed, dir_tab[n].lvl);
            end
        end

        // Random phases, each with fresh thresholds and weight; one runs without gaps.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            idle_en = (ph != 3);
            mode = $urandom_range(4);
            case (mode)
                0: begin
                    full_v  = FULL_RST;
                    empty_v = EMPTY_RST;
                end
                1: begin
                    empty_v = $urandom_range(60000, 0);
                    full_v  = empty_v + $urandom_range(5000, 1);
                    if (full_v > 65535) full_v = 65535;
                end
                2: begin
                    empty_v = $urandom_range(65535, 0);
                    full_v  = $urandom_range(empty_v, 0);
                end
                3: begin
                    full_v  = 65535;
                    empty_v = 0;
                end
                default: begin
                    full_v  = $urandom_range(65535, 1);
                    empty_v = $urandom_range(full_v - 1, 0);
                end
            endcase
            case ($urandom_range(5))
                0: alpha_v = 16'd1;
                1: alpha_v = 16'd65535;
                2: alpha_v = ALPHA_RST;
                3: alpha_v = MV_W'($urandom_range(2000, 1));
                default: alpha_v = MV_W'($urandom_range(65535, 1));
            endcase
            write_reg(CFG_FULL, MV_W'(full_v));
            write_reg(CFG_EMPTY, MV_W'(empty_v));
            write_reg(CFG_ALPHA, alpha_v);
            for (int k = 0; k < PHASE_LEN; k++) send_request(pick_sample(), 1'b0, '0);
        end

        drain();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatches == 0 && pending_levels.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
